// ===== rtl/ipcm_pkg.sv =====
package ipcm_pkg;

  // fixed field widths of the request and result ports
  localparam int SEAT_W  = 11;
  localparam int COLOR_W = 7;

  // request command codes
  localparam logic CMD_PAINT  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // sequencer states
  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_REDUCE = 8'b0000_0100,
    S_PAINT  = 8'b0000_1000,
    S_CCLR   = 8'b0001_0000,
    S_HIST   = 8'b0010_0000,
    S_PEAK   = 8'b0100_0000,
    S_SCAN   = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/ipcm_ram.sv =====
module ipcm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/interval_paint_color_mode.sv =====
// Paint request: busy while the color is folded into the palette and the clipped range is
//   written (no write for an empty range); the next request is taken once busy is low.
// Finish request: the histogram is cleared, the clipped seats are counted and the colors are
//   scanned; out_valid strobes on the same edge on which busy drops.
// One request in work at a time; results strobe for one cycle, the receiver cannot stall.
// Reset (rst_n low, synchronous) then clears every seat RAM entry, with busy high until done.
module interval_paint_color_mode #(
  parameter int SEATS  = 1024,
  parameter int COLORS = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [ipcm_pkg::SEAT_W-1:0]  in_first_seat,
  input  logic [ipcm_pkg::SEAT_W-1:0]  in_last_seat,
  input  logic [ipcm_pkg::COLOR_W-1:0] in_paint_color,
  output logic                         out_valid,
  output logic [ipcm_pkg::COLOR_W-1:0] out_most_color,
  output logic [ipcm_pkg::COLOR_W-1:0] out_least_color,
  input  logic                         cfg_we,
  input  logic [ipcm_pkg::SEAT_W-1:0]  cfg_wdata
);

  import ipcm_pkg::*;

  localparam int AW = $clog2(SEATS);
  localparam int CW = $clog2(COLORS);
  localparam int KW = $clog2(SEATS + 1);
  localparam int PW = (KW > SEAT_W) ? KW : SEAT_W;

  // control registers
  state_t           state_r, state_nxt;
  logic [SEAT_W-1:0] num_seats_r;
  logic [KW-1:0]    sptr_r, sptr_nxt;
  logic [CW-1:0]    cptr_r, cptr_nxt;
  logic             cdone_r, cdone_nxt;
  logic             first_r, first_nxt;
  logic             v1_r, v1_nxt;
  logic             v2_r, v2_nxt;
  logic             fw_v_r, fw_v_nxt;
  logic             sv_r, sv_nxt;
  logic             go_r, go_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  logic             cmd_r, cmd_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic [PW-1:0]    hi_r, hi_nxt;
  logic [KW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    c0_r, c0_nxt;
  logic [CW-1:0]    c2_r, c2_nxt;
  logic [CW-1:0]    fw_c_r, fw_c_nxt;
  logic [KW-1:0]    fw_k_r, fw_k_nxt;
  logic [CW-1:0]    sc_r, sc_nxt;
  logic [CW-1:0]    most_r, most_nxt;
  logic [CW-1:0]    least_r, least_nxt;
  logic [KW-1:0]    most_cnt_r, most_cnt_nxt;
  logic [KW-1:0]    least_cnt_r, least_cnt_nxt;

  // memory ports
  logic             seat_we;
  logic [AW-1:0]    seat_waddr, seat_raddr;
  logic [CW-1:0]    seat_wdata, seat_rdata;
  logic             cnt_we;
  logic [CW-1:0]    cnt_waddr, cnt_raddr;
  logic [KW-1:0]    cnt_wdata, cnt_rdata;

  // local decode
  logic [PW-1:0]    lo_c, hi_c;
  logic             issue;
  logic [KW-1:0]    base, inc;

  ipcm_ram #(.W(CW), .D(SEATS)) u_seat_ram (
    .clk   (clk),
    .we    (seat_we),
    .waddr (seat_waddr),
    .wdata (seat_wdata),
    .raddr (seat_raddr),
    .rdata (seat_rdata)
  );

  ipcm_ram #(.W(KW), .D(COLORS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // range clipping of an incoming paint request
  always_comb begin
    lo_c = (in_first_seat == '0) ? PW'(1) : PW'(in_first_seat);
    hi_c = (32'(in_last_seat) > 32'(SEATS)) ? PW'(SEATS) : PW'(in_last_seat);
  end

  // histogram increment with forwarding of the preceding histogram write
  always_comb begin
    base = (fw_v_r && (fw_c_r == c2_r)) ? fw_k_r : cnt_rdata;
    inc  = base + KW'(1);
  end

  assign issue = (sptr_r < n_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sptr_nxt      = sptr_r;
    cptr_nxt      = cptr_r;
    cdone_nxt     = cdone_r;
    first_nxt     = first_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    fw_v_nxt      = fw_v_r;
    sv_nxt        = sv_r;
    go_nxt        = go_r;
    out_valid_nxt = 1'b0;
    cmd_nxt       = cmd_r;
    color_nxt     = color_r;
    ptr_nxt       = ptr_r;
    hi_nxt        = hi_r;
    n_nxt         = n_r;
    c0_nxt        = c0_r;
    c2_nxt        = c2_r;
    fw_c_nxt      = fw_c_r;
    fw_k_nxt      = fw_k_r;
    sc_nxt        = sc_r;
    most_nxt      = most_r;
    least_nxt     = least_r;
    most_cnt_nxt  = most_cnt_r;
    least_cnt_nxt = least_cnt_r;
    seat_we       = 1'b0;
    seat_waddr    = '0;
    seat_wdata    = '0;
    seat_raddr    = '0;
    cnt_we        = 1'b0;
    cnt_waddr     = '0;
    cnt_wdata     = '0;
    cnt_raddr     = '0;

    case (state_r)
      // clear the seat store after reset
      S_INIT: begin
        seat_we    = 1'b1;
        seat_waddr = AW'(sptr_r);
        if (sptr_r == KW'(SEATS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          sptr_nxt = sptr_r + KW'(1);
        end
      end

      // take a request
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_cmd;
          color_nxt = in_paint_color;
          ptr_nxt   = lo_c;
          hi_nxt    = hi_c;
          go_nxt    = (in_first_seat <= in_last_seat) && (lo_c <= hi_c);
          n_nxt     = (32'(num_seats_r) > 32'(SEATS)) ? KW'(SEATS) : KW'(num_seats_r);
          cptr_nxt  = '0;
          if (in_cmd == CMD_FINISH) begin
            state_nxt = S_CCLR;
          end else begin
            state_nxt = S_REDUCE;
          end
        end
      end

      // fold the paint color into the palette
      S_REDUCE: begin
        if (32'(color_r) >= 32'(COLORS)) begin
          color_nxt = color_r - COLOR_W'(COLORS);
        end else if (go_r) begin
          state_nxt = S_PAINT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // write the range, one seat a cycle
      S_PAINT: begin
        seat_we    = 1'b1;
        seat_waddr = AW'(ptr_r - PW'(1));
        seat_wdata = CW'(color_r);
        if (ptr_r == hi_r) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end

      // clear the histogram, fetch the color of seat 1
      S_CCLR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = cptr_r;
        seat_raddr = '0;
        c0_nxt     = seat_rdata;
        if (cptr_r == CW'(COLORS - 1)) begin
          state_nxt = S_HIST;
          sptr_nxt  = '0;
          v1_nxt    = 1'b0;
          v2_nxt    = 1'b0;
          fw_v_nxt  = 1'b0;
        end else begin
          cptr_nxt = cptr_r + CW'(1);
        end
      end

      // seat read, count read, count write: one seat enters a cycle
      S_HIST: begin
        seat_raddr = AW'(sptr_r);
        v1_nxt     = issue;
        if (issue) begin
          sptr_nxt = sptr_r + KW'(1);
        end
        cnt_raddr = seat_rdata;
        v2_nxt    = v1_r;
        c2_nxt    = seat_rdata;
        fw_v_nxt  = v2_r;
        if (v2_r) begin
          cnt_we    = 1'b1;
          cnt_waddr = c2_r;
          cnt_wdata = inc;
          fw_c_nxt  = c2_r;
          fw_k_nxt  = inc;
        end
        if (!issue && !v1_r && !v2_r) begin
          state_nxt = S_PEAK;
        end
      end

      // read the count of the starting candidate
      S_PEAK: begin
        cnt_raddr = c0_r;
        cptr_nxt  = '0;
        cdone_nxt = 1'b0;
        first_nxt = 1'b1;
        sv_nxt    = 1'b0;
        state_nxt = S_SCAN;
      end

      // scan colors upward with separate compares for most and least
      S_SCAN: begin
        if (first_r) begin
          most_nxt      = c0_r;
          least_nxt     = c0_r;
          most_cnt_nxt  = cnt_rdata;
          least_cnt_nxt = cnt_rdata;
          first_nxt     = 1'b0;
        end else if (sv_r && (cnt_rdata != '0)) begin
          if (cnt_rdata > most_cnt_r) begin
            most_nxt     = sc_r;
            most_cnt_nxt = cnt_rdata;
          end
          if (cnt_rdata < least_cnt_r) begin
            least_nxt     = sc_r;
            least_cnt_nxt = cnt_rdata;
          end
        end
        cnt_raddr = cptr_r;
        sv_nxt    = !cdone_r;
        sc_nxt    = cptr_r;
        if (!cdone_r) begin
          if (cptr_r == CW'(COLORS - 1)) begin
            cdone_nxt = 1'b1;
          end else begin
            cptr_nxt = cptr_r + CW'(1);
          end
        end
        if (cdone_r && !sv_r && !first_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      num_seats_r <= SEAT_W'(1024);
      sptr_r      <= '0;
      cptr_r      <= '0;
      cdone_r     <= 1'b0;
      first_r     <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      fw_v_r      <= 1'b0;
      sv_r        <= 1'b0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        num_seats_r <= cfg_wdata;
      end
      sptr_r      <= sptr_nxt;
      cptr_r      <= cptr_nxt;
      cdone_r     <= cdone_nxt;
      first_r     <= first_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      fw_v_r      <= fw_v_nxt;
      sv_r        <= sv_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    color_r     <= color_nxt;
    ptr_r       <= ptr_nxt;
    hi_r        <= hi_nxt;
    n_r         <= n_nxt;
    c0_r        <= c0_nxt;
    c2_r        <= c2_nxt;
    fw_c_r      <= fw_c_nxt;
    fw_k_r      <= fw_k_nxt;
    sc_r        <= sc_nxt;
    most_r      <= most_nxt;
    least_r     <= least_nxt;
    most_cnt_r  <= most_cnt_nxt;
    least_cnt_r <= least_cnt_nxt;
  end

  // outputs
  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_most_color  = COLOR_W'(most_r);
  assign out_least_color = COLOR_W'(least_r);

  // a finish request must end its scan before a result shows
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_SCAN))
    else $error("result strobe without a completed scan");

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

  // one strobe per finish
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // histogram is written only while clearing or counting
  a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> (state_r == S_CCLR || state_r == S_HIST))
    else $error("histogram write outside a finish");

endmodule
